/* rtl/atgs_pkg.sv */
// ----------------------------------------------------------------------------
// atgs_pkg: gear selector shared types and constants
// Mode codes, register indexes and the structs passed between the selector
// stages.
// ----------------------------------------------------------------------------
package atgs_pkg;

  localparam int unsigned MaxGears = 3;
  localparam int unsigned NumRatios = 4;
  localparam int unsigned RevLane = 3;

  localparam logic [14:0] Q15One = 15'd32767;

  // gear mode state, one-hot
  typedef enum logic [3:0] {
    ModeParked  = 4'b0001,
    ModeNeutral = 4'b0010,
    ModeDrive   = 4'b0100,
    ModeReverse = 4'b1000
  } mode_e;

  // gear mode codes on the result port
  localparam logic [1:0] GearCodeParked  = 2'd0;
  localparam logic [1:0] GearCodeNeutral = 2'd1;
  localparam logic [1:0] GearCodeDrive   = 2'd2;
  localparam logic [1:0] GearCodeReverse = 2'd3;

  typedef enum logic [2:0] {
    CfgForwardGears   = 3'd0,
    CfgIdleRpm        = 3'd1,
    CfgRedlineRpm     = 3'd2,
    CfgSelectDeadzone = 3'd3,
    CfgStandstillRpm  = 3'd4,
    CfgShiftThresh    = 3'd5,
    CfgEngineBrake    = 3'd6,
    CfgGearRatios     = 3'd7
  } cfg_idx_e;

  // effective configuration
  typedef struct packed {
    logic [1:0]                  n;
    logic [13:0]                 idle;
    logic [13:0]                 red;
    logic [14:0]                 dz;
    logic [13:0]                 still_rpm;
    logic [15:0]                 up;
    logic [15:0]                 down;
    logic [14:0]                 ebrake;
    logic [NumRatios-1:0][15:0]  ratio;
  } cfg_t;

  typedef struct packed {
    logic [14:0] fd;
    logic [14:0] rev_thr;
    logic [14:0] brake;
    logic [14:0] hand;
    logic [15:0] steer;
    logic        wheel_neg;
    logic [16:0] wabs;
  } s1_t;

  typedef struct packed {
    logic [NumRatios-1:0][24:0] prod;
    logic [28:0]                nprod;
    logic                       still;
    logic [14:0]                fd;
    logic [14:0]                rev_thr;
    logic [14:0]                rev_sel;
    logic [14:0]                brake;
    logic [14:0]                hand;
    logic [15:0]                steer;
    logic                       wheel_neg;
  } s2_t;

  function automatic logic [1:0] mode_code(mode_e m);
    logic [1:0] c;
    case (m)
      ModeParked:  c = GearCodeParked;
      ModeNeutral: c = GearCodeNeutral;
      ModeDrive:   c = GearCodeDrive;
      ModeReverse: c = GearCodeReverse;
      default:     c = GearCodeNeutral;
    endcase
    return c;
  endfunction

endpackage

/* rtl/auto_transmission_gear_selector.sv */
// ----------------------------------------------------------------------------
// auto_transmission_gear_selector: automatic gearbox mode and gear control
// Three stage pipeline: input register, ratio multiply, shift and result.
// ----------------------------------------------------------------------------
// a word passes the input register, the ratio register and the result register in order
// throughput: one word per cycle while out_ready_i is not held low; gear state updates in the last stage only
// the four 17x16 ratio multipliers and the 15x14 neutral product sit in the
// middle stage
// reset: gear mode neutral, first gear, pipeline empty, setup registers at
// their defaults
module auto_transmission_gear_selector import atgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [63:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] throttle_i,
  input  logic        [14:0] brake_pedal_i,
  input  logic        [14:0] handbrake_lever_i,
  input  logic signed [15:0] steer_i,
  input  logic signed [15:0] wheel_rpm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [1:0]  gear_mode_o,
  output logic        [1:0]  forward_gear_o,
  output logic        [13:0] engine_rpm_o,
  output logic        [14:0] throttle_drive_o,
  output logic        [14:0] brake_drive_o,
  output logic        [14:0] handbrake_drive_o,
  output logic signed [15:0] steer_drive_o
);

  cfg_t cfg;
  s2_t  s2;
  logic s2_valid, s2_ready;

  atgs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  atgs_prep u_prep (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .throttle_i       (throttle_i),
    .brake_pedal_i    (brake_pedal_i),
    .handbrake_lever_i(handbrake_lever_i),
    .steer_i          (steer_i),
    .wheel_rpm_i      (wheel_rpm_i),
    .s2_valid_o       (s2_valid),
    .s2_o             (s2),
    .s2_ready_i       (s2_ready)
  );

  atgs_shift u_shift (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .s2_valid_i       (s2_valid),
    .s2_i             (s2),
    .s2_ready_o       (s2_ready),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .gear_mode_o      (gear_mode_o),
    .forward_gear_o   (forward_gear_o),
    .engine_rpm_o     (engine_rpm_o),
    .throttle_drive_o (throttle_drive_o),
    .brake_drive_o    (brake_drive_o),
    .handbrake_drive_o(handbrake_drive_o),
    .steer_drive_o    (steer_drive_o)
  );

endmodule

/* rtl/atgs_cfg.sv */
// ----------------------------------------------------------------------------
// atgs_cfg: configuration registers
// Holds the setup registers and derives the effective gear count and redline.
// ----------------------------------------------------------------------------
module atgs_cfg import atgs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  logic [1:0]  fwd_gears_q;
  logic [13:0] idle_q;
  logic [13:0] red_q;
  logic [14:0] dz_q;
  logic [13:0] still_q;
  logic [31:0] thresh_q;
  logic [14:0] ebrake_q;
  logic [63:0] ratios_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_gears_q <= 2'd3;
      idle_q      <= 14'd800;
      red_q       <= 14'd6500;
      dz_q        <= 15'd3277;
      still_q     <= 14'd10;
      thresh_q    <= 32'd360450000;
      ebrake_q    <= '0;
      ratios_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgForwardGears:   fwd_gears_q <= cfg_wdata_i[1:0];
        CfgIdleRpm:        idle_q      <= cfg_wdata_i[13:0];
        CfgRedlineRpm:     red_q       <= cfg_wdata_i[13:0];
        CfgSelectDeadzone: dz_q        <= cfg_wdata_i[14:0];
        CfgStandstillRpm:  still_q     <= cfg_wdata_i[13:0];
        CfgShiftThresh:    thresh_q    <= cfg_wdata_i[31:0];
        CfgEngineBrake:    ebrake_q    <= cfg_wdata_i[14:0];
        CfgGearRatios:     ratios_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    // zero gears means one, capped at the gearbox size
    if (fwd_gears_q == 2'd0) begin
      cfg_o.n = 2'd1;
    end else if (32'(fwd_gears_q) > MaxGears) begin
      cfg_o.n = 2'(MaxGears);
    end else begin
      cfg_o.n = fwd_gears_q;
    end
    cfg_o.idle      = idle_q;
    cfg_o.red       = (red_q > idle_q) ? red_q : idle_q;
    cfg_o.dz        = dz_q;
    cfg_o.still_rpm = still_q;
    cfg_o.up        = thresh_q[31:16];
    cfg_o.down      = thresh_q[15:0];
    cfg_o.ebrake    = ebrake_q;
    for (int k = 0; k < NumRatios; k++) begin
      cfg_o.ratio[k] = ratios_q[16*k +: 16];
    end
  end

endmodule

/* rtl/atgs_prep.sv */
// ----------------------------------------------------------------------------
// atgs_prep: input register and ratio multiply stage
// Clamps the driver axes, takes the wheel magnitude and forms the raw engine
// speed for every ratio plus the neutral rpm product.
// ----------------------------------------------------------------------------
module atgs_prep import atgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] throttle_i,
  input  logic        [14:0] brake_pedal_i,
  input  logic        [14:0] handbrake_lever_i,
  input  logic signed [15:0] steer_i,
  input  logic signed [15:0] wheel_rpm_i,
  output logic               s2_valid_o,
  output s2_t                s2_o,
  input  logic               s2_ready_i
);

  logic  s1_valid_q, s2_valid_q;
  logic  s1_ready, s2_ready;
  s1_t   s1_d, s1_q;
  s2_t   s2_d, s2_q;
  logic signed [15:0] thr_c;
  logic [13:0] span;

  assign s2_ready   = !s2_valid_q || s2_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

  always_comb begin
    // only the most negative code is outside the axis range
    thr_c = (throttle_i == 16'sh8000) ? -16'sd32767 : throttle_i;
    s1_d.fd      = (thr_c > 16'sd0) ? thr_c[14:0] : '0;
    s1_d.rev_thr = (thr_c < 16'sd0) ? 15'(-thr_c) : '0;
    s1_d.brake   = brake_pedal_i;
    s1_d.hand    = handbrake_lever_i;
    s1_d.steer   = (steer_i == 16'sh8000) ? 16'h8001 : steer_i;
    s1_d.wheel_neg = wheel_rpm_i[15];
    s1_d.wabs    = wheel_rpm_i[15] ? 17'(-{wheel_rpm_i[15], wheel_rpm_i})
                                   : {1'b0, wheel_rpm_i};
  end

  always_comb begin
    logic [32:0] p;
    span = cfg_i.red - cfg_i.idle;
    for (int k = 0; k < NumRatios; k++) begin
      p = 33'(s1_q.wabs) * 33'(cfg_i.ratio[k]);
      s2_d.prod[k] = p[32:8];
    end
    s2_d.nprod     = 29'(s1_q.fd) * 29'(span);
    s2_d.still     = s1_q.wabs <= {3'b0, cfg_i.still_rpm};
    s2_d.fd        = s1_q.fd;
    s2_d.rev_thr   = s1_q.rev_thr;
    s2_d.rev_sel   = (s1_q.rev_thr > s1_q.brake) ? s1_q.rev_thr : s1_q.brake;
    s2_d.brake     = s1_q.brake;
    s2_d.hand      = s1_q.hand;
    s2_d.steer     = s1_q.steer;
    s2_d.wheel_neg = s1_q.wheel_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q && s2_ready) begin
      s2_q <= s2_d;
    end
  end

endmodule

/* rtl/atgs_shift.sv */
// ----------------------------------------------------------------------------
// atgs_shift: gear mode, shift logic and result register
// Clamps the per-gear engine speeds, steps the gear mode and index and
// registers the actuator commands.
// ----------------------------------------------------------------------------
module atgs_shift import atgs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               s2_valid_i,
  input  s2_t                s2_i,
  output logic               s2_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [1:0]  gear_mode_o,
  output logic        [1:0]  forward_gear_o,
  output logic        [13:0] engine_rpm_o,
  output logic        [14:0] throttle_drive_o,
  output logic        [14:0] brake_drive_o,
  output logic        [14:0] handbrake_drive_o,
  output logic signed [15:0] steer_drive_o
);

  mode_e mode_d, mode_q;
  logic [1:0]  idx_d, idx_q;
  logic        out_valid_q;
  logic        take;
  logic [1:0]  n_m1;
  logic [NumRatios-1:0][13:0] rpm_c;
  logic [13:0] neutral_rpm;
  logic [13:0] nq0, nq;
  logic [15:0] nr;
  logic [14:0] nsum;
  logic        go_fwd, go_rev, hand_on;
  logic [13:0] rpm_d, rpm_q;
  logic [14:0] thr_d, thr_q, brk_d, brk_q, hnd_d, hnd_q;
  logic [15:0] steer_q;

  assign s2_ready_o = !out_valid_q || out_ready_i;
  assign take       = s2_valid_i && s2_ready_o;
  assign n_m1       = cfg_i.n - 2'd1;

  // engine speed per ratio, clamped to idle..redline
  always_comb begin
    for (int k = 0; k < NumRatios; k++) begin
      if (s2_i.prod[k] < {11'b0, cfg_i.idle}) begin
        rpm_c[k] = cfg_i.idle;
      end else if (s2_i.prod[k] > {11'b0, cfg_i.red}) begin
        rpm_c[k] = cfg_i.red;
      end else begin
        rpm_c[k] = s2_i.prod[k][13:0];
      end
    end
  end

  // divide by 32767: quotient by shift, then one correction step
  always_comb begin
    nq0  = s2_i.nprod[28:15];
    nr   = {1'b0, s2_i.nprod[14:0]} + {2'b0, nq0};
    nq   = (nr >= {1'b0, Q15One}) ? nq0 + 14'd1 : nq0;
    nsum = {1'b0, cfg_i.idle} + {1'b0, nq};
    neutral_rpm = (nsum > {1'b0, cfg_i.red}) ? cfg_i.red : nsum[13:0];
  end

  always_comb begin
    mode_d  = mode_q;
    idx_d   = idx_q;
    go_fwd  = s2_i.fd > cfg_i.dz;
    go_rev  = s2_i.rev_sel > cfg_i.dz;
    hand_on = s2_i.hand != '0;

    // park is released by a forward go-demand, or by a reverse one with the handbrake off
    if (mode_q == ModeParked && (go_fwd || (!hand_on && go_rev))) begin
      mode_d = ModeNeutral;
    end
    if (mode_d != ModeParked) begin
      if (s2_i.still) begin
        if (hand_on && !go_fwd && !go_rev) begin
          mode_d = ModeParked;
        end else if (go_fwd) begin
          mode_d = ModeDrive;
          idx_d  = '0;
        end else if (go_rev) begin
          mode_d = ModeReverse;
        end else begin
          mode_d = ModeNeutral;
        end
      end else if (mode_d == ModeNeutral) begin
        // rolling neutral follows the wheel direction
        mode_d = s2_i.wheel_neg ? ModeReverse : ModeDrive;
      end
    end

    if (mode_d == ModeDrive) begin
      if (idx_d > n_m1) begin
        idx_d = n_m1;
      end
      for (int s = 0; s < MaxGears - 1; s++) begin
        if (idx_d < n_m1 && {2'b0, rpm_c[idx_d]} >= cfg_i.up) begin
          idx_d = idx_d + 2'd1;
        end
      end
      for (int s = 0; s < MaxGears - 1; s++) begin
        if (idx_d != 2'd0 && {2'b0, rpm_c[idx_d]} <= cfg_i.down) begin
          idx_d = idx_d - 2'd1;
        end
      end
    end

    thr_d = '0;
    brk_d = s2_i.brake;
    hnd_d = s2_i.hand;
    case (mode_d)
      ModeParked: begin
        rpm_d = neutral_rpm;
        brk_d = Q15One;
        hnd_d = Q15One;
      end
      ModeDrive: begin
        rpm_d = rpm_c[idx_d];
        thr_d = s2_i.fd;
        // engine braking when coasting
        if (s2_i.fd == '0 && !s2_i.still && cfg_i.ebrake > s2_i.brake) begin
          brk_d = cfg_i.ebrake;
        end
      end
      ModeReverse: begin
        rpm_d = rpm_c[RevLane];
        thr_d = s2_i.rev_thr;
        if (s2_i.fd > s2_i.brake) begin
          brk_d = s2_i.fd;
        end
      end
      default: begin
        rpm_d = neutral_rpm;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeNeutral;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q      <= mode_d;
        idx_q       <= idx_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rpm_q   <= rpm_d;
      thr_q   <= thr_d;
      brk_q   <= brk_d;
      hnd_q   <= hnd_d;
      steer_q <= s2_i.steer;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign gear_mode_o       = mode_code(mode_q);
  assign forward_gear_o    = idx_q;
  assign engine_rpm_o      = rpm_q;
  assign throttle_drive_o  = thr_q;
  assign brake_drive_o     = brk_q;
  assign handbrake_drive_o = hnd_q;
  assign steer_drive_o     = steer_q;

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for auto_transmission_gear_selector
// A random-gap driver feeds control words from a queue, a stalling monitor
// checks every result against an in-bench gearbox model, and the setup
// registers are reloaded between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb import atgs_pkg::*;;

  localparam int FullScale = int'(Q15One);

  typedef struct packed {
    logic [15:0] thr;
    logic [14:0] brake;
    logic [14:0] hand;
    logic [15:0] steer;
    logic [15:0] wheel;
  } ctl_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  gear;
    logic [13:0] rpm;
    logic [14:0] throttle;
    logic [14:0] brake;
    logic [14:0] handbrake;
    logic [15:0] steer;
  } gear_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic        [2:0]  cfg_idx_i = '0;
  logic        [63:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] throttle_i = '0;
  logic        [14:0] brake_pedal_i = '0;
  logic        [14:0] handbrake_lever_i = '0;
  logic signed [15:0] steer_i = '0;
  logic signed [15:0] wheel_rpm_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic        [1:0]  gear_mode_o;
  logic        [1:0]  forward_gear_o;
  logic        [13:0] engine_rpm_o;
  logic        [14:0] throttle_drive_o;
  logic        [14:0] brake_drive_o;
  logic        [14:0] handbrake_drive_o;
  logic signed [15:0] steer_drive_o;

  auto_transmission_gear_selector u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .throttle_i       (throttle_i),
    .brake_pedal_i    (brake_pedal_i),
    .handbrake_lever_i(handbrake_lever_i),
    .steer_i          (steer_i),
    .wheel_rpm_i      (wheel_rpm_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .gear_mode_o      (gear_mode_o),
    .forward_gear_o   (forward_gear_o),
    .engine_rpm_o     (engine_rpm_o),
    .throttle_drive_o (throttle_drive_o),
    .brake_drive_o    (brake_drive_o),
    .handbrake_drive_o(handbrake_drive_o),
    .steer_drive_o    (steer_drive_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // gearbox state and setup as the block should hold them
  logic [1:0]  st_mode = GearCodeNeutral;
  logic [1:0]  st_gear = '0;
  int unsigned st_rpm = 0;

  logic [1:0]  cfg_fwd = 2'd3;
  logic [13:0] cfg_idle = 14'd800;
  logic [13:0] cfg_red = 14'd6500;
  logic [14:0] cfg_dz = 15'd3277;
  logic [13:0] cfg_still = 14'd10;
  logic [31:0] cfg_shift = 32'd360450000;
  logic [14:0] cfg_ebrake = '0;
  logic [63:0] cfg_ratios = '0;

  ctl_word_t    pending_words[$];
  gear_result_t results_due[$];
  int unsigned  mismatches = 0;

  ctl_word_t    tx_word = '0;
  int unsigned  tx_gap = 0;
  int unsigned  tx_burst = 0;
  int unsigned  rx_stall = 0;
  int unsigned  rx_burst = 0;
  gear_result_t rx_seen;
  gear_result_t rx_want;

  function automatic int clamp_q15(int v);
    if (v > FullScale) return FullScale;
    if (v < -FullScale) return -FullScale;
    return v;
  endfunction

  function automatic int unsigned geared_rpm(int unsigned wabs, int unsigned ratio,
                                             int unsigned idle, int unsigned red);
    longint unsigned raw;
    raw = wabs;
    raw = (raw * ratio) >> 8;
    if (raw < idle) raw = idle;
    if (raw > red) raw = red;
    return 32'(raw);
  endfunction

  // one control tick: update the gearbox state, return the actuator word
  function automatic gear_result_t step_gearbox(ctl_word_t w);
    int           thr, steer, wheel;
    int unsigned  brake, hand, n, idle, red, dz, up, down;
    int unsigned  fd, rev_thr, rev_sel, wabs, g, t_out, b_out, h_out;
    bit           still;
    gear_result_t r;
    thr = clamp_q15($signed(w.thr));
    steer = clamp_q15($signed(w.steer));
    wheel = $signed(w.wheel);
    brake = w.brake;
    hand = w.hand;
    n = cfg_fwd;
    if (n < 1) n = 1;
    if (n > MaxGears) n = MaxGears;
    idle = cfg_idle;
    red = (cfg_red > cfg_idle) ? cfg_red : cfg_idle;
    dz = cfg_dz;
    up = cfg_shift[31:16];
    down = cfg_shift[15:0];
    fd = (thr > 0) ? thr : 0;
    rev_thr = (thr < 0) ? -thr : 0;
    rev_sel = (rev_thr > brake) ? rev_thr : brake;
    wabs = (wheel < 0) ? -wheel : wheel;
    still = (wabs <= cfg_still);

    // park holds until a go demand releases it
    if (st_mode == GearCodeParked && (fd > dz || (hand == 0 && rev_sel > dz)))
      st_mode = GearCodeNeutral;
    if (st_mode != GearCodeParked) begin
      if (still) begin
        if (hand != 0 && fd <= dz && rev_sel <= dz) begin
          st_mode = GearCodeParked;
        end else if (fd > dz) begin
          st_mode = GearCodeDrive;
          st_gear = '0;
        end else if (rev_sel > dz) begin
          st_mode = GearCodeReverse;
        end else begin
          st_mode = GearCodeNeutral;
        end
      end else if (st_mode == GearCodeNeutral) begin
        // rolling neutral engages by direction of travel
        if (wheel >= 0) begin
          st_mode = GearCodeDrive;
          if (st_gear > n - 1) st_gear = 2'(n - 1);
        end else begin
          st_mode = GearCodeReverse;
        end
      end
    end

    if (st_mode == GearCodeDrive) begin
      if (st_gear > n - 1) st_gear = 2'(n - 1);
      st_rpm = geared_rpm(wabs, cfg_ratios[16*st_gear +: 16], idle, red);
      for (g = 0; st_gear < n - 1 && st_rpm >= up && g < n; g++) begin
        st_gear++;
        st_rpm = geared_rpm(wabs, cfg_ratios[16*st_gear +: 16], idle, red);
      end
      for (g = 0; st_gear > 0 && st_rpm <= down && g < n; g++) begin
        st_gear--;
        st_rpm = geared_rpm(wabs, cfg_ratios[16*st_gear +: 16], idle, red);
      end
    end else if (st_mode == GearCodeReverse) begin
      st_rpm = geared_rpm(wabs, cfg_ratios[63:48], idle, red);
    end else begin
      st_rpm = idle + (fd * (red - idle)) / FullScale;
      if (st_rpm > red) st_rpm = red;
    end

    t_out = 0;
    b_out = 0;
    h_out = hand;
    case (st_mode)
      GearCodeParked: begin
        b_out = FullScale;
        h_out = FullScale;
      end
      GearCodeDrive: begin
        t_out = fd;
        // engine braking only when coasting on the move
        if (fd == 0 && !still) b_out = (brake > cfg_ebrake) ? brake : cfg_ebrake;
        else b_out = brake;
      end
      GearCodeReverse: begin
        t_out = rev_thr;
        b_out = (brake > fd) ? brake : fd;
      end
      default: begin
        b_out = brake;
      end
    endcase

    r.mode = st_mode;
    r.gear = st_gear;
    r.rpm = st_rpm[13:0];
    r.throttle = t_out[14:0];
    r.brake = b_out[14:0];
    r.handbrake = h_out[14:0];
    r.steer = steer[15:0];
    return r;
  endfunction

  function automatic int unsigned next_gap(inout int unsigned burst);
    int unsigned r;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) results_due.push_back(step_gearbox(tx_word));
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          tx_word = pending_words.pop_front();
          throttle_i <= tx_word.thr;
          brake_pedal_i <= tx_word.brake;
          handbrake_lever_i <= tx_word.hand;
          steer_i <= tx_word.steer;
          wheel_rpm_i <= tx_word.wheel;
          in_valid_i <= 1'b1;
          tx_gap = next_gap(tx_burst);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        rx_seen.mode = gear_mode_o;
        rx_seen.gear = forward_gear_o;
        rx_seen.rpm = engine_rpm_o;
        rx_seen.throttle = throttle_drive_o;
        rx_seen.brake = brake_drive_o;
        rx_seen.handbrake = handbrake_drive_o;
        rx_seen.steer = steer_drive_o;
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result word mode=%0d gear=%0d rpm=%0d",
                     rx_seen.mode, rx_seen.gear, rx_seen.rpm);
        end else begin
          rx_want = results_due.pop_front();
          if (rx_seen !== rx_want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: exp mode=%0d gear=%0d rpm=%0d thr=%0d brk=%0d hb=%0d str=%0d",
                       rx_want.mode, rx_want.gear, rx_want.rpm, rx_want.throttle,
                       rx_want.brake, rx_want.handbrake, $signed(rx_want.steer));
              $display("       got mode=%0d gear=%0d rpm=%0d thr=%0d brk=%0d hb=%0d str=%0d",
                       rx_seen.mode, rx_seen.gear, rx_seen.rpm, rx_seen.throttle,
                       rx_seen.brake, rx_seen.handbrake, $signed(rx_seen.steer));
            end
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else begin
        rx_stall = next_gap(rx_burst);
        out_ready_i <= (rx_stall == 0);
      end
    end
  end

  function automatic ctl_word_t mk_word(int thr, int brake, int hand, int steer, int wheel);
    ctl_word_t w;
    w.thr = thr[15:0];
    w.brake = brake[14:0];
    w.hand = hand[14:0];
    w.steer = steer[15:0];
    w.wheel = wheel[15:0];
    return w;
  endfunction

  function automatic int rnd_axis();
    case ($urandom_range(0, 11))
      0: return -32768;
      1: return 32767;
      2: return -32767;
      3: return 0;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic int rnd_q15();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32767;
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  function automatic int over_dz();
    if (cfg_dz >= 15'd32767) return 32767;
    return $urandom_range(cfg_dz + 1, 32767);
  endfunction

  function automatic int under_dz();
    return $urandom_range(0, cfg_dz);
  endfunction

  function automatic int still_wheel();
    int v;
    v = $urandom_range(0, cfg_still);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic int moving_wheel(int unsigned extra);
    int unsigned v;
    v = cfg_still + 1 + extra;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  function automatic int small_brake();
    return ($urandom_range(0, 3) == 0) ? rnd_q15() : 0;
  endfunction

  // one driving maneuver with random content, or a burst of noise
  task automatic add_maneuver(inout int unsigned count);
    int unsigned kind, steps, peak, i;
    kind = $urandom_range(0, 99);
    steps = $urandom_range(4, 12);
    peak = ($urandom_range(0, 9) < 7) ? $urandom_range(50, 3000) : $urandom_range(0, 32767);
    if (kind < 35) begin
      // pull away, accelerate through the gears, coast and brake to a stop
      pending_words.push_back(mk_word(over_dz(), 0, 0, rnd_axis(), still_wheel()));
      for (i = 1; i <= steps; i++)
        pending_words.push_back(mk_word($urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 32767),
                                        small_brake(), 0, rnd_axis(),
                                        moving_wheel(peak * i / steps)));
      for (i = steps; i > 0; i--)
        pending_words.push_back(mk_word($urandom_range(0, 3) == 0 ? rnd_axis() : 0,
                                        small_brake(), 0, rnd_axis(),
                                        moving_wheel(peak * (i - 1) / steps)));
      pending_words.push_back(mk_word(0, rnd_q15(), 0, rnd_axis(), still_wheel()));
      count += 2 * steps + 2;
    end else if (kind < 55) begin
      // select reverse at rest, back up and stop
      if ($urandom_range(0, 1))
        pending_words.push_back(mk_word(-over_dz(), 0, 0, rnd_axis(), still_wheel()));
      else
        pending_words.push_back(mk_word(0, over_dz(), 0, rnd_axis(), still_wheel()));
      for (i = 1; i <= steps; i++)
        pending_words.push_back(mk_word(-int'($urandom_range(0, 32767)), small_brake(), 0,
                                        rnd_axis(), -moving_wheel(peak * i / steps)));
      pending_words.push_back(mk_word(0, rnd_q15(), 0, rnd_axis(), still_wheel()));
      count += steps + 2;
    end else if (kind < 70) begin
      // park, get pushed around while parked, then drive off
      pending_words.push_back(mk_word($urandom_range(0, 1) ? under_dz() : -under_dz(),
                                      under_dz(), $urandom_range(1, 32767), rnd_axis(),
                                      still_wheel()));
      steps = $urandom_range(1, 4);
      for (i = 0; i < steps; i++)
        pending_words.push_back(mk_word(under_dz(), rnd_q15(), rnd_q15(), rnd_axis(),
                                        rnd_axis()));
      if ($urandom_range(0, 1))
        pending_words.push_back(mk_word(over_dz(), 0, rnd_q15(), rnd_axis(), still_wheel()));
      else
        pending_words.push_back(mk_word(0, over_dz(), 0, rnd_axis(), still_wheel()));
      count += steps + 2;
    end else if (kind < 80) begin
      // settle in neutral, then start rolling either way
      pending_words.push_back(mk_word(under_dz(), under_dz(), 0, rnd_axis(), still_wheel()));
      steps = $urandom_range(1, 3);
      for (i = 0; i < steps; i++)
        pending_words.push_back(mk_word(rnd_axis(), rnd_q15(), 0, rnd_axis(),
                                        ($urandom_range(0, 1) ? 1 : -1) *
                                        moving_wheel($urandom_range(0, peak))));
      count += steps + 1;
    end else begin
      steps = $urandom_range(1, 4);
      for (i = 0; i < steps; i++)
        pending_words.push_back(mk_word(rnd_axis(), rnd_q15(), rnd_q15(), rnd_axis(),
                                        rnd_axis()));
      count += steps;
    end
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CfgForwardGears:   cfg_fwd = val[1:0];
      CfgIdleRpm:        cfg_idle = val[13:0];
      CfgRedlineRpm:     cfg_red = val[13:0];
      CfgSelectDeadzone: cfg_dz = val[14:0];
      CfgStandstillRpm:  cfg_still = val[13:0];
      CfgShiftThresh:    cfg_shift = val[31:0];
      CfgEngineBrake:    cfg_ebrake = val[14:0];
      CfgGearRatios:     cfg_ratios = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [1:0] fwd, logic [13:0] idle, logic [13:0] red,
                            logic [14:0] dz, logic [13:0] still, logic [31:0] shift,
                            logic [14:0] ebrake, logic [63:0] ratios);
    set_reg(CfgForwardGears, 64'(fwd));
    set_reg(CfgIdleRpm, 64'(idle));
    set_reg(CfgRedlineRpm, 64'(red));
    set_reg(CfgSelectDeadzone, 64'(dz));
    set_reg(CfgStandstillRpm, 64'(still));
    set_reg(CfgShiftThresh, 64'(shift));
    set_reg(CfgEngineBrake, 64'(ebrake));
    set_reg(CfgGearRatios, ratios);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // mostly plausible values, now and then anything the register holds
  task automatic load_random_setup();
    logic [63:0] ratios;
    logic [31:0] shift;
    int unsigned k;
    for (k = 0; k < NumRatios; k++)
      ratios[16*k +: 16] = 16'(($urandom_range(0, 9) < 6) ? $urandom_range(128, 1024)
                                                          : $urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 6) shift = {16'($urandom_range(3000, 7000)),
                                            16'($urandom_range(1000, 3000))};
    else shift = $urandom;
    load_setup(2'($urandom_range(0, 3)),
               14'(($urandom_range(0, 9) < 6) ? $urandom_range(500, 1200)
                                              : $urandom_range(0, 16383)),
               14'(($urandom_range(0, 9) < 6) ? $urandom_range(4000, 8000)
                                              : $urandom_range(0, 16383)),
               15'(($urandom_range(0, 9) < 6) ? $urandom_range(1000, 8000)
                                              : $urandom_range(0, 32767)),
               14'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 50)
                                              : $urandom_range(0, 16383)),
               shift, 15'($urandom_range(0, 32767)), ratios);
  endtask

  task automatic run_random(int unsigned budget);
    int unsigned count;
    count = 0;
    while (count < budget) add_maneuver(count);
  endtask

  // pipeline empty and nothing left in flight, sampled once the edge has settled
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ratios 3.5, 2.0, 1.0, reverse 3.0; shift up 5500 down 2000
    load_setup(2'd3, 14'd800, 14'd6500, 15'd3277, 14'd10, 32'h157C_07D0, 15'd4000,
               64'h0300_0100_0200_0380);
    pending_words.push_back(mk_word(0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(-32768, 0, 0, -32768, 0));
    pending_words.push_back(mk_word(0, 0, 32767, 32767, 0));
    pending_words.push_back(mk_word(0, 32767, 1, 0, 500));
    pending_words.push_back(mk_word(32767, 0, 32767, 0, 0));
    pending_words.push_back(mk_word(20000, 0, 0, 0, 1000));
    pending_words.push_back(mk_word(20000, 0, 0, 0, 1700));
    pending_words.push_back(mk_word(32767, 0, 0, 32767, 32767));
    pending_words.push_back(mk_word(0, 0, 0, 0, 300));
    pending_words.push_back(mk_word(0, 32767, 0, 0, 5));
    pending_words.push_back(mk_word(-20000, 0, 0, 0, -200));
    pending_words.push_back(mk_word(10000, 100, 0, 0, -100));
    pending_words.push_back(mk_word(0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(0, 0, 0, 0, 11));
    pending_words.push_back(mk_word(0, 0, 0, 0, -10));
    pending_words.push_back(mk_word(0, 0, 0, 0, -11));
    wait_idle();

    load_random_setup();
    run_random(80);
    wait_idle();

    // zero gear count, redline under idle, no deadzone, max ratios
    load_setup(2'd0, 14'd16383, 14'd0, 15'd0, 14'd0, 32'h0000_0000, 15'd32767,
               64'hFFFF_FFFF_FFFF_FFFF);
    pending_words.push_back(mk_word(0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(1, 0, 0, 0, 1));
    pending_words.push_back(mk_word(0, 0, 5, 0, 0));
    pending_words.push_back(mk_word(0, 32767, 0, 0, -32768));
    run_random(50);
    wait_idle();

    // single gear, deadzone at full scale, wide standstill, zero ratios
    load_setup(2'd1, 14'd0, 14'd16383, 15'd32767, 14'd16383, 32'hFFFF_FFFF, 15'd0,
               64'h0);
    pending_words.push_back(mk_word(32767, 0, 0, 0, 0));
    pending_words.push_back(mk_word(32767, 0, 0, 0, 16383));
    pending_words.push_back(mk_word(-32768, 32767, 32767, 0, -16384));
    pending_words.push_back(mk_word(0, 0, 0, 0, 0));
    pending_words.push_back(mk_word(32767, 0, 1, 0, 0));
    run_random(50);
    wait_idle();

    for (phase = 0; phase < 3; phase++) begin
      load_random_setup();
      run_random(70);
      wait_idle();
    end

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASS auto_transmission_gear_selector");
    end else begin
      $display("FAIL auto_transmission_gear_selector");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL auto_transmission_gear_selector");
    $finish;
  end

endmodule
